>>> design/rgpt_pkg.sv
package rgpt_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int WLEN_W      = 11;
   localparam int STEP_W      = 16;
   localparam int GATE_W      = 24;
   localparam int RANGE_W     = 40;
   localparam int POWER_W     = 2 * SAMPLE_BITS;

   // default longest window
   localparam int MAX_WINDOW_DEF = 1024;

   // window length after clamping, wide enough for the largest window bound
   localparam int LEN_W  = 17;
   // gate plus peak index, index up to 16 bits
   localparam int POS_W  = GATE_W + 1;
   // gate plus index minus half window, before saturation
   localparam int GSUM_W = GATE_W + 2;

   // configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // reset values of the registers
   localparam logic [WLEN_W-1:0]        WINDOW_LEN_RESET = WLEN_W'(100);
   localparam logic [STEP_W-1:0]        RANGE_STEP_RESET = STEP_W'(3840);
   localparam logic signed [GATE_W-1:0] INIT_GATE_RESET  = GATE_W'(100);

   typedef enum logic [1:0] {
      REG_WINDOW_LEN = 2'd0,
      REG_RANGE_STEP = 2'd1,
      REG_INIT_GATE  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WLEN_W-1:0]        window_len;
      logic [STEP_W-1:0]        range_step;
      logic signed [GATE_W-1:0] init_gate;
      logic                     load_gate;
      logic signed [GATE_W-1:0] load_value;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          track_on;
   } sample_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          track_on;
      logic [POWER_W-1:0]            power;
   } power_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          done;
      logic signed [POS_W-1:0]       pos;
      logic signed [GATE_W-1:0]      gate;
   } track_item_type;

endpackage

>>> design/rgpt_csr.sv
module rgpt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rgpt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [rgpt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [rgpt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output rgpt_pkg::cfg_type             cfg
);

   logic [rgpt_pkg::WLEN_W-1:0]        window_len_ff, window_len_in;
   logic [rgpt_pkg::STEP_W-1:0]        range_step_ff, range_step_in;
   logic signed [rgpt_pkg::GATE_W-1:0] init_gate_ff, init_gate_in;
   logic                               wr_en;
   rgpt_pkg::reg_index_type            reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = rgpt_pkg::reg_index_type'(csr_paddr[3:2]);

   // decode the write
   always_comb begin
      window_len_in = window_len_ff;
      range_step_in = range_step_ff;
      init_gate_in  = init_gate_ff;
      if (wr_en) begin
         case (reg_idx)
            rgpt_pkg::REG_WINDOW_LEN: window_len_in = csr_pwdata[rgpt_pkg::WLEN_W-1:0];
            rgpt_pkg::REG_RANGE_STEP: range_step_in = csr_pwdata[rgpt_pkg::STEP_W-1:0];
            rgpt_pkg::REG_INIT_GATE:  init_gate_in  = csr_pwdata[rgpt_pkg::GATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= rgpt_pkg::WINDOW_LEN_RESET;
         range_step_ff <= rgpt_pkg::RANGE_STEP_RESET;
         init_gate_ff  <= rgpt_pkg::INIT_GATE_RESET;
      end else begin
         window_len_ff <= window_len_in;
         range_step_ff <= range_step_in;
         init_gate_ff  <= init_gate_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         rgpt_pkg::REG_WINDOW_LEN:
            csr_prdata = rgpt_pkg::DATA_W'(window_len_ff);
         rgpt_pkg::REG_RANGE_STEP:
            csr_prdata = rgpt_pkg::DATA_W'(range_step_ff);
         rgpt_pkg::REG_INIT_GATE:
            csr_prdata = rgpt_pkg::DATA_W'(init_gate_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // a gate write also reloads the running gate in the tracker
   always_comb begin
      cfg.window_len = window_len_ff;
      cfg.range_step = range_step_ff;
      cfg.init_gate  = init_gate_ff;
      cfg.load_gate  = wr_en && (reg_idx == rgpt_pkg::REG_INIT_GATE);
      cfg.load_value = csr_pwdata[rgpt_pkg::GATE_W-1:0];
   end

endmodule

>>> design/rgpt_power.sv
module rgpt_power (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rgpt_pkg::sample_type     in_item,
   output logic                     in_ready,
   output logic                     out_valid,
   output rgpt_pkg::power_item_type out_item,
   input  logic                     out_ready
);

   localparam int PW = rgpt_pkg::POWER_W;

   logic                     v0_ff, v0_in, v1_ff, v1_in;
   logic                     rdy0, rdy1;
   rgpt_pkg::sample_type     s0_ff, s0_in;
   rgpt_pkg::power_item_type s1_ff, s1_in;
   logic signed [PW-1:0]     sq_re, sq_im;

   assign rdy1     = !v1_ff || out_ready;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   // square both parts; each square stays below the top bit
   assign sq_re = s0_ff.re * s0_ff.re;
   assign sq_im = s0_ff.im * s0_ff.im;

   // advance the two stages
   always_comb begin
      v0_in = rdy0 ? in_valid : v0_ff;
      s0_in = (rdy0 && in_valid) ? in_item : s0_ff;
      v1_in = rdy1 ? v0_ff : v1_ff;
      s1_in = s1_ff;
      if (rdy1 && v0_ff) begin
         s1_in.re       = s0_ff.re;
         s1_in.im       = s0_ff.im;
         s1_in.track_on = s0_ff.track_on;
         s1_in.power    = PW'(sq_re[PW-2:0]) + PW'(sq_im[PW-2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign out_valid = v1_ff;
   assign out_item  = s1_ff;

endmodule

>>> design/rgpt_track.sv
module rgpt_track #(
   parameter int MAX_WINDOW = rgpt_pkg::MAX_WINDOW_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rgpt_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   input  rgpt_pkg::power_item_type in_item,
   output logic                     in_ready,
   output logic                     out_valid,
   output rgpt_pkg::track_item_type out_item,
   input  logic                     out_ready
);

   localparam int IDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW    = rgpt_pkg::LEN_W;
   localparam int GW    = rgpt_pkg::GATE_W;
   localparam int SW    = rgpt_pkg::GSUM_W;
   localparam int PW    = rgpt_pkg::POS_W;

   logic                     v_ff, v_in;
   rgpt_pkg::track_item_type s_ff, s_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         peak_idx_ff, peak_idx_in;
   logic [rgpt_pkg::POWER_W-1:0] peak_pow_ff, peak_pow_in;
   logic                     tracked_ff, tracked_in;
   logic signed [GW-1:0]     gate_ff, gate_in;

   logic                     fire, first, tracked, better, last;
   logic [LW-1:0]            wlen, len_eff, half;
   logic [rgpt_pkg::POWER_W-1:0] base_pow, new_pow;
   logic [IDX_W-1:0]         base_idx, new_idx;
   logic signed [PW-1:0]     pos_sum;
   logic signed [SW-1:0]     gate_sum;
   logic [SW-GW:0]           gate_top;
   logic signed [GW-1:0]     gate_new;

   assign in_ready = !v_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // clamp the window length to its legal range
   always_comb begin
      wlen = LW'(cfg.window_len);
      if (wlen < LW'(2))
         len_eff = LW'(2);
      else if (wlen > LW'(MAX_WINDOW))
         len_eff = LW'(MAX_WINDOW);
      else
         len_eff = wlen;
      half = len_eff >> 1;
   end

   // running peak over the window
   always_comb begin
      first    = (pos_ff == '0);
      tracked  = first ? in_item.track_on : tracked_ff;
      base_pow = first ? '0 : peak_pow_ff;
      base_idx = first ? '0 : peak_idx_ff;
      better   = tracked && (in_item.power > base_pow);
      new_pow  = better ? in_item.power : base_pow;
      new_idx  = better ? pos_ff : base_idx;
      last     = LW'(pos_ff) >= (len_eff - LW'(1));
   end

   // range position and moved gate, saturated to the gate width
   always_comb begin
      pos_sum  = PW'(gate_ff) + signed'(PW'(new_idx));
      gate_sum = SW'(gate_ff) + signed'(SW'(new_idx)) - signed'(SW'(half));
      gate_top = gate_sum[SW-1:GW-1];
      if ((&gate_top) || !(|gate_top))
         gate_new = gate_sum[GW-1:0];
      else if (gate_sum[SW-1])
         gate_new = {1'b1, {(GW-1){1'b0}}};
      else
         gate_new = {1'b0, {(GW-1){1'b1}}};
   end

   // update window state and the stage register
   always_comb begin
      v_in        = in_ready ? in_valid : v_ff;
      s_in        = s_ff;
      pos_in      = pos_ff;
      peak_idx_in = peak_idx_ff;
      peak_pow_in = peak_pow_ff;
      tracked_in  = tracked_ff;
      gate_in     = gate_ff;
      if (fire) begin
         s_in.re     = tracked ? in_item.re : '0;
         s_in.im     = tracked ? in_item.im : '0;
         s_in.done   = last;
         s_in.pos    = (last && tracked) ? pos_sum : '0;
         s_in.gate   = last ? (tracked ? gate_new : cfg.init_gate) : '0;
         pos_in      = last ? '0 : pos_ff + IDX_W'(1);
         peak_idx_in = new_idx;
         peak_pow_in = new_pow;
         tracked_in  = tracked;
         if (last && tracked)
            gate_in = gate_new;
      end
      if (cfg.load_gate)
         gate_in = cfg.load_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= 1'b0;
         pos_ff      <= '0;
         peak_idx_ff <= '0;
         peak_pow_ff <= '0;
         tracked_ff  <= 1'b0;
         gate_ff     <= rgpt_pkg::INIT_GATE_RESET;
      end else begin
         v_ff        <= v_in;
         pos_ff      <= pos_in;
         peak_idx_ff <= peak_idx_in;
         peak_pow_ff <= peak_pow_in;
         tracked_ff  <= tracked_in;
         gate_ff     <= gate_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign out_valid = v_ff;
   assign out_item  = s_ff;

endmodule

>>> design/rgpt_range.sv
module rgpt_range (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rgpt_pkg::cfg_type                    cfg,
   input  logic                                 in_valid,
   input  rgpt_pkg::track_item_type             in_item,
   output logic                                 in_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_re,
   output logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_im,
   output logic                                 rsp_window_done,
   output logic signed [rgpt_pkg::RANGE_W-1:0]  rsp_range_out,
   output logic signed [rgpt_pkg::GATE_W-1:0]   rsp_gate_out
);

   localparam int RW     = rgpt_pkg::RANGE_W;
   localparam int PROD_W = rgpt_pkg::POS_W + rgpt_pkg::STEP_W + 1;

   logic                                  v_ff, v_in;
   logic signed [rgpt_pkg::SAMPLE_BITS-1:0] re_ff, re_in, im_ff, im_in;
   logic                                  done_ff, done_in;
   logic signed [RW-1:0]                  range_ff, range_in;
   logic signed [rgpt_pkg::GATE_W-1:0]    gate_ff, gate_in;
   logic signed [PROD_W-1:0]              prod;
   logic [PROD_W-RW:0]                    prod_top;
   logic signed [RW-1:0]                  range_sat;

   assign in_ready = !v_ff || !rsp_stall;

   // range product, saturated to the output width
   always_comb begin
      prod     = PROD_W'(in_item.pos) * signed'(PROD_W'(cfg.range_step));
      prod_top = prod[PROD_W-1:RW-1];
      if ((&prod_top) || !(|prod_top))
         range_sat = prod[RW-1:0];
      else if (prod[PROD_W-1])
         range_sat = {1'b1, {(RW-1){1'b0}}};
      else
         range_sat = {1'b0, {(RW-1){1'b1}}};
   end

   // load the output register when it is free or taken
   always_comb begin
      v_in     = in_ready ? in_valid : v_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      done_in  = done_ff;
      range_in = range_ff;
      gate_in  = gate_ff;
      if (in_ready && in_valid) begin
         re_in    = in_item.re;
         im_in    = in_item.im;
         done_in  = in_item.done;
         range_in = range_sat;
         gate_in  = in_item.gate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else
         v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      re_ff    <= re_in;
      im_ff    <= im_in;
      done_ff  <= done_in;
      range_ff <= range_in;
      gate_ff  <= gate_in;
   end

   assign rsp_valid       = v_ff;
   assign rsp_out_re      = re_ff;
   assign rsp_out_im      = im_ff;
   assign rsp_window_done = done_ff;
   assign rsp_range_out   = range_ff;
   assign rsp_gate_out    = gate_ff;

endmodule

>>> design/range_gate_peak_tracker.sv
// Range gate peak tracker.
// Input channel (req_): one complex fast-time sample per item, plus the track
// flag, which counts only on the first sample of a window. Result channel
// (rsp_): one item per input item, in order: the passed sample (zero in an
// untracked window), window_done on the last sample, and on that sample the range
// (peak position times range_step) and moved gate, or 0 and init_gate if untracked.
// Configuration goes through the csr_ APB port: window_len at 0x0, range_step
// at 0x4, init_gate at 0x8; writing init_gate also reloads the running gate.
// Write it only while no item is in flight.
// rsp_valid rises through four registers after the accepting edge:
// input register, squared magnitude stage, window tracking stage, range
// multiply into the output register. One item is taken every cycle unless
// req_stall is high; the tracking stage does the peak compare and gate update combinationally.
// Reset clears all stage valids, the window position and the peak, and loads
// the registers and the running gate with their defaults.
// While rsp_stall is high the output item holds; the stages behind it keep
// filling, and req_stall rises once all four are occupied.
module range_gate_peak_tracker #(
   parameter int MAX_WINDOW = rgpt_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rgpt_pkg::SAMPLE_BITS-1:0] req_sample_re,
   input  logic signed [rgpt_pkg::SAMPLE_BITS-1:0] req_sample_im,
   input  logic                                 req_track_on,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_re,
   output logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_im,
   output logic                                 rsp_window_done,
   output logic signed [rgpt_pkg::RANGE_W-1:0]  rsp_range_out,
   output logic signed [rgpt_pkg::GATE_W-1:0]   rsp_gate_out,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rgpt_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [rgpt_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [rgpt_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   rgpt_pkg::cfg_type        cfg;
   rgpt_pkg::sample_type     req_item;
   rgpt_pkg::power_item_type pow_item;
   rgpt_pkg::track_item_type trk_item;
   logic                     pow_in_ready, pow_valid, trk_in_ready;
   logic                     trk_valid, rng_in_ready;

   // gather the input item
   always_comb begin
      req_item.re       = req_sample_re;
      req_item.im       = req_sample_im;
      req_item.track_on = req_track_on;
   end

   assign req_stall = !pow_in_ready;

   rgpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rgpt_power u_power (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .in_ready  (pow_in_ready),
      .out_valid (pow_valid),
      .out_item  (pow_item),
      .out_ready (trk_in_ready)
   );

   rgpt_track #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (pow_valid),
      .in_item   (pow_item),
      .in_ready  (trk_in_ready),
      .out_valid (trk_valid),
      .out_item  (trk_item),
      .out_ready (rng_in_ready)
   );

   rgpt_range u_range (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (trk_valid),
      .in_item         (trk_item),
      .in_ready        (rng_in_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_window_done (rsp_window_done),
      .rsp_range_out   (rsp_range_out),
      .rsp_gate_out    (rsp_gate_out)
   );

endmodule

>>> design/rgpt_checker.sv
module rgpt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_re,
   input logic signed [rgpt_pkg::SAMPLE_BITS-1:0] rsp_out_im,
   input logic                                 rsp_window_done,
   input logic signed [rgpt_pkg::RANGE_W-1:0]  rsp_range_out,
   input logic signed [rgpt_pkg::GATE_W-1:0]   rsp_gate_out
);

   // hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_re) &&
      $stable(rsp_out_im) && $stable(rsp_window_done) &&
      $stable(rsp_range_out) && $stable(rsp_gate_out))
      else $error("stalled result item changed");

   // drop the output after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stall the input only when the whole pipeline is blocked at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // range and gate are zero except on the last sample of a window
   a_not_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_done |-> rsp_range_out == '0 && rsp_gate_out == '0)
      else $error("range or gate set before window end");

endmodule

bind range_gate_peak_tracker rgpt_checker u_checker (.*);
